// ===== src/fla_pkg.sv =====
// Shared types and constants for the facility location dual ascent block.
package fla_pkg;

   localparam int ValW   = 24;
   localparam int BoundW = 29;
   localparam int ModeW  = 3;
   localparam int IdxW   = 5;
   localparam int CountW = 6;
   localparam int RankW  = 5;

   localparam logic [ValW-1:0]   ValMax   = '1;
   localparam logic [BoundW-1:0] BoundMax = '1;

   localparam logic CSR_NUM_FACILITIES = 1'b0;
   localparam logic CSR_NUM_CLIENTS    = 1'b1;

   typedef enum logic [ModeW-1:0] {
      MODE_COST  = 3'd0,
      MODE_OPEN  = 3'd1,
      MODE_RANK  = 3'd2,
      MODE_DUAL  = 3'd3,
      MODE_START = 3'd4
   } mode_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_INIT_RD,
      S_INIT_FAC,
      S_INIT_FIRST,
      S_INIT_KRD,
      S_INIT_KFAC,
      S_INIT_KCMP,
      S_INIT_DONE,
      S_SLACK_RD,
      S_SLACK_WR,
      S_PASS,
      S_CL_START,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_GAP_RD,
      S_GAP_FAC,
      S_GAP_CMP,
      S_UPD_RD,
      S_UPD_WR,
      S_CL_END,
      S_SUM_RD,
      S_SUM_ACC,
      S_EMIT_RD,
      S_EMIT_WR
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [IdxW-1:0]   client;
      logic [ValW-1:0]   multiplier;
      logic [BoundW-1:0] bound;
      logic              last;
   } emit_type;

endpackage

// ===== src/fla_ram.sv =====
// Generic single write port RAM with registered read.
module fla_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr,
   input  logic [Width-1:0]                      wdata,
   input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr,
   output logic [Width-1:0]                      rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/fla_engine.sv =====
// Dual ascent sequencer with its cost, rank, open cost, slack, multiplier and rank pointer memories.
module fla_engine #(
   parameter int MAX_FACILITIES = 32,
   parameter int MAX_CLIENTS    = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   load,
   input  logic                                   start,
   input  logic [fla_pkg::ModeW-1:0]              mode,
   input  logic [fla_pkg::IdxW-1:0]               row,
   input  logic [fla_pkg::IdxW-1:0]               col,
   input  logic [fla_pkg::ValW-1:0]               value,
   input  logic [$clog2(MAX_FACILITIES+1)-1:0]    nf,
   input  logic [$clog2(MAX_CLIENTS+1)-1:0]       nc,
   input  logic                                   out_free,
   output logic                                   busy,
   output fla_pkg::emit_type                      emit
);
   import fla_pkg::*;

   localparam int FAW   = $clog2(MAX_FACILITIES);
   localparam int CAW   = MAX_CLIENTS > 1 ? $clog2(MAX_CLIENTS) : 1;
   localparam int NFW   = $clog2(MAX_FACILITIES + 1);
   localparam int NCW   = $clog2(MAX_CLIENTS + 1);
   localparam int TDEP  = 2 ** (FAW + CAW);

   state_type state_ff, state_in;

   logic [NCW-1:0]            j_ff, j_in;
   logic [NFW-1:0]            i_ff, i_in;
   logic [NFW-1:0]            k_ff, k_in;
   logic [ValW-1:0]           mul_ff, mul_in;
   logic [ValW-1:0]           delta_ff, delta_in;
   logic                      inc_ff, inc_in;
   logic                      again_ff, again_in;
   logic                      oob_ff, oob_in;
   logic [BoundW-1:0]         acc_ff, acc_in;
   logic [MAX_FACILITIES-1:0] cov_ff, cov_in;

   logic                  cost_we, rank_we, open_we, slack_we, dual_we, nr_we;
   logic [FAW+CAW-1:0]    cost_waddr, cost_raddr, rank_waddr, rank_raddr;
   logic [ValW-1:0]       cost_rdata, open_rdata, slack_rdata, dual_rdata;
   logic [ValW-1:0]       slack_wdata, dual_wdata, open_wdata;
   logic [RankW-1:0]      rank_rdata;
   logic [FAW-1:0]        open_waddr, open_raddr, slack_addr;
   logic [CAW-1:0]        dual_waddr, cli;
   logic [NFW-1:0]        nr_rdata, nr_wdata;

   logic                  row_ok, col_ok, is_load_mode;
   logic [FAW-1:0]        row_f, i_f, rank_f;
   logic [CAW-1:0]        col_c;
   logic [ValW-1:0]       rc, gap;
   logic                  i_last, j_last;
   logic [ValW:0]         mul_sum;
   logic [BoundW:0]       acc_sum;

   assign cli     = j_ff[CAW-1:0];
   assign i_f     = i_ff[FAW-1:0];
   assign row_f   = FAW'(row);
   assign col_c   = CAW'(col);
   assign rank_f  = FAW'(rank_rdata);
   assign row_ok  = 32'(row) < MAX_FACILITIES;
   assign col_ok  = 32'(col) < MAX_CLIENTS;
   assign is_load_mode = load;
   assign rc      = oob_ff ? '0 : cost_rdata;
   assign gap     = rc > dual_rdata ? rc - dual_rdata : '0;
   assign i_last  = (32'(i_ff) + 1) == 32'(nf);
   assign j_last  = (32'(j_ff) + 1) == 32'(nc);
   assign mul_sum = {1'b0, dual_rdata} + {1'b0, delta_ff};
   assign acc_sum = {1'b0, acc_ff} + (BoundW+1)'(dual_rdata);
   assign busy    = state_ff != S_IDLE;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:       if (start) state_in = S_INIT_RD;
         S_INIT_RD:    state_in = S_INIT_FAC;
         S_INIT_FAC:   state_in = S_INIT_FIRST;
         S_INIT_FIRST: state_in = S_INIT_KRD;
         S_INIT_KRD:   state_in = (k_ff < nf) ? S_INIT_KFAC : S_INIT_DONE;
         S_INIT_KFAC:  state_in = S_INIT_KCMP;
         S_INIT_KCMP:  state_in = (mul_ff >= rc) ? S_INIT_KRD : S_INIT_DONE;
         S_INIT_DONE:  state_in = j_last ? S_SLACK_RD : S_INIT_RD;
         S_SLACK_RD:   state_in = S_SLACK_WR;
         S_SLACK_WR:   state_in = i_last ? S_PASS : S_SLACK_RD;
         S_PASS:       state_in = S_CL_START;
         S_CL_START:   state_in = S_SCAN_RD;
         S_SCAN_RD:    state_in = S_SCAN_CMP;
         S_SCAN_CMP:   state_in = i_last ? S_GAP_RD : S_SCAN_RD;
         S_GAP_RD:     state_in = (nr_rdata < nf) ? S_GAP_FAC : S_UPD_RD;
         S_GAP_FAC:    state_in = S_GAP_CMP;
         S_GAP_CMP:    state_in = S_UPD_RD;
         S_UPD_RD:     state_in = S_UPD_WR;
         S_UPD_WR:     state_in = i_last ? S_CL_END : S_UPD_RD;
         S_CL_END: begin
            if (!j_last) state_in = S_CL_START;
            else if (again_ff) state_in = S_PASS;
            else state_in = S_SUM_RD;
         end
         S_SUM_RD:     state_in = S_SUM_ACC;
         S_SUM_ACC:    state_in = j_last ? S_EMIT_RD : S_SUM_RD;
         S_EMIT_RD:    state_in = S_EMIT_WR;
         S_EMIT_WR: begin
            if (out_free) state_in = j_last ? S_IDLE : S_EMIT_RD;
         end
         default:      state_in = S_IDLE;
      endcase
   end

   // memory controls and result
   always_comb begin
      cost_we     = is_load_mode && mode == MODE_COST && row_ok && col_ok;
      cost_waddr  = {row_f, col_c};
      rank_we     = is_load_mode && mode == MODE_RANK && row_ok && col_ok;
      rank_waddr  = {row_f, col_c};
      open_we     = is_load_mode && mode == MODE_OPEN && row_ok;
      open_waddr  = row_f;
      open_wdata  = value;
      open_raddr  = i_f;
      dual_we     = is_load_mode && mode == MODE_DUAL && col_ok;
      dual_waddr  = is_load_mode ? col_c : cli;
      dual_wdata  = value;
      nr_we       = 1'b0;
      nr_wdata    = k_ff;
      slack_we    = 1'b0;
      slack_addr  = i_f;
      slack_wdata = open_rdata;
      cost_raddr  = {rank_f, cli};
      rank_raddr  = {FAW'(0), cli};
      emit        = '0;
      unique case (state_ff)
         S_INIT_KRD: rank_raddr = {k_ff[FAW-1:0], cli};
         S_INIT_DONE: begin
            dual_we    = 1'b1;
            dual_wdata = mul_ff;
            nr_we      = 1'b1;
         end
         S_SLACK_WR: slack_we = 1'b1;
         S_SCAN_RD:  cost_raddr = {i_f, cli};
         S_GAP_RD:   rank_raddr = {nr_rdata[FAW-1:0], cli};
         S_UPD_WR: begin
            slack_we    = cov_ff[i_f];
            slack_wdata = slack_rdata >= delta_ff ? slack_rdata - delta_ff : '0;
         end
         S_CL_END: begin
            dual_we    = 1'b1;
            dual_wdata = mul_sum[ValW] ? ValMax : mul_sum[ValW-1:0];
            nr_we      = 1'b1;
            nr_wdata   = nr_rdata + NFW'(inc_ff);
         end
         S_EMIT_WR: begin
            emit.valid      = out_free;
            emit.client     = IdxW'(j_ff);
            emit.multiplier = dual_rdata;
            emit.bound      = acc_ff;
            emit.last       = j_last;
         end
         default: ;
      endcase
   end

   // datapath registers
   always_comb begin
      j_in     = j_ff;
      i_in     = i_ff;
      k_in     = k_ff;
      mul_in   = mul_ff;
      delta_in = delta_ff;
      inc_in   = inc_ff;
      again_in = again_ff;
      oob_in   = 32'(rank_rdata) >= MAX_FACILITIES;
      acc_in   = acc_ff;
      cov_in   = cov_ff;
      unique case (state_ff)
         S_IDLE: j_in = '0;
         S_INIT_FIRST: begin
            mul_in = dual_rdata < rc ? rc : dual_rdata;
            k_in   = '0;
         end
         S_INIT_KCMP: if (mul_ff >= rc) k_in = k_ff + 1'b1;
         S_INIT_DONE: begin
            j_in = j_last ? '0 : j_ff + 1'b1;
            i_in = '0;
         end
         S_SLACK_WR: i_in = i_last ? '0 : i_ff + 1'b1;
         S_PASS: begin
            again_in = 1'b0;
            j_in     = '0;
         end
         S_CL_START: begin
            i_in     = '0;
            delta_in = ValMax;
            inc_in   = 1'b0;
         end
         S_SCAN_CMP: begin
            cov_in[i_f] = dual_rdata >= cost_rdata;
            if (dual_rdata >= cost_rdata && slack_rdata < delta_ff) delta_in = slack_rdata;
            i_in = i_last ? '0 : i_ff + 1'b1;
         end
         S_GAP_CMP: begin
            if (delta_ff > gap) begin
               delta_in = gap;
               inc_in   = 1'b1;
               again_in = 1'b1;
            end
         end
         S_UPD_WR: i_in = i_last ? '0 : i_ff + 1'b1;
         S_CL_END: begin
            j_in   = j_last ? '0 : j_ff + 1'b1;
            acc_in = '0;
         end
         S_SUM_ACC: begin
            acc_in = acc_sum > (BoundW+1)'(BoundMax) ? BoundMax : acc_sum[BoundW-1:0];
            j_in   = j_last ? '0 : j_ff + 1'b1;
         end
         S_EMIT_WR: if (out_free) j_in = j_last ? '0 : j_ff + 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      j_ff     <= j_in;
      i_ff     <= i_in;
      k_ff     <= k_in;
      mul_ff   <= mul_in;
      delta_ff <= delta_in;
      inc_ff   <= inc_in;
      again_ff <= again_in;
      oob_ff   <= oob_in;
      acc_ff   <= acc_in;
      cov_ff   <= cov_in;
   end

   fla_ram #(.Width(ValW), .Depth(TDEP)) u_cost (
      .clock(clock), .we(cost_we), .waddr(cost_waddr), .wdata(value),
      .raddr(cost_raddr), .rdata(cost_rdata)
   );

   fla_ram #(.Width(RankW), .Depth(TDEP)) u_rank (
      .clock(clock), .we(rank_we), .waddr(rank_waddr), .wdata(value[RankW-1:0]),
      .raddr(rank_raddr), .rdata(rank_rdata)
   );

   fla_ram #(.Width(ValW), .Depth(MAX_FACILITIES)) u_open (
      .clock(clock), .we(open_we), .waddr(open_waddr), .wdata(open_wdata),
      .raddr(open_raddr), .rdata(open_rdata)
   );

   fla_ram #(.Width(ValW), .Depth(MAX_FACILITIES)) u_slack (
      .clock(clock), .we(slack_we), .waddr(slack_addr), .wdata(slack_wdata),
      .raddr(slack_addr), .rdata(slack_rdata)
   );

   fla_ram #(.Width(ValW), .Depth(MAX_CLIENTS)) u_dual (
      .clock(clock), .we(dual_we), .waddr(dual_waddr), .wdata(dual_wdata),
      .raddr(cli), .rdata(dual_rdata)
   );

   fla_ram #(.Width(NFW), .Depth(MAX_CLIENTS)) u_next_rank (
      .clock(clock), .we(nr_we), .waddr(cli), .wdata(nr_wdata),
      .raddr(cli), .rdata(nr_rdata)
   );

endmodule

// ===== src/facility_location_dual_ascent.sv =====
// Top level: item handshake, count registers and result register around the ascent engine.
//
// Load items (modes 0 to 3) write straight into the tables and are accepted back to back;
// unknown modes are dropped. A start item runs the ascent out of memories with one write
// port and a registered read: a ranking walk per client sets the first multipliers, the
// open costs are copied into the slack table for every facility, and ascent passes then
// run over all clients. Passes repeat until none hits a rank cap. A summing sweep over the
// clients precedes the results, which leave one client at a time and wait while rsp_ready
// is low. No item is taken while a start is being worked on.
module facility_location_dual_ascent #(
   parameter int MAX_FACILITIES = 32,
   parameter int MAX_CLIENTS    = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [fla_pkg::ModeW-1:0]       req_mode,
   input  logic [fla_pkg::IdxW-1:0]        req_row,
   input  logic [fla_pkg::IdxW-1:0]        req_col,
   input  logic [fla_pkg::ValW-1:0]        req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [fla_pkg::IdxW-1:0]        rsp_client,
   output logic [fla_pkg::ValW-1:0]        rsp_multiplier,
   output logic [fla_pkg::BoundW-1:0]      rsp_bound,
   output logic                            rsp_last,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [fla_pkg::CountW-1:0]      csr_wdata
);
   import fla_pkg::*;

   localparam int NFW    = $clog2(MAX_FACILITIES + 1);
   localparam int NCW    = $clog2(MAX_CLIENTS + 1);
   localparam int CLimit = MAX_CLIENTS < 32 ? MAX_CLIENTS : 32;

   logic [CountW-1:0] num_fac_ff, num_fac_in, num_cli_ff, num_cli_in;
   logic              rsp_valid_ff, rsp_valid_in;
   emit_type          out_ff, out_in;
   emit_type          emit;
   logic              busy, accept, load, start, out_free;
   logic [NFW-1:0]    nf;
   logic [NCW-1:0]    nc;

   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;
   assign start     = accept && req_mode == MODE_START;
   assign load      = accept && req_mode != MODE_START;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (num_fac_ff == '0) nf = NFW'(1);
      else if (32'(num_fac_ff) > MAX_FACILITIES) nf = NFW'(MAX_FACILITIES);
      else nf = NFW'(num_fac_ff);
      if (num_cli_ff == '0) nc = NCW'(1);
      else if (32'(num_cli_ff) > CLimit) nc = NCW'(CLimit);
      else nc = NCW'(num_cli_ff);
   end

   always_comb begin
      num_fac_in = num_fac_ff;
      num_cli_in = num_cli_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_FACILITIES: num_fac_in = csr_wdata;
            CSR_NUM_CLIENTS:    num_cli_in = csr_wdata;
            default: ;
         endcase
      end
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
         out_in       = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_fac_ff   <= CountW'(32);
         num_cli_ff   <= CountW'(32);
         rsp_valid_ff <= 1'b0;
      end else begin
         num_fac_ff   <= num_fac_in;
         num_cli_ff   <= num_cli_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_client     = out_ff.client;
   assign rsp_multiplier = out_ff.multiplier;
   assign rsp_bound      = out_ff.bound;
   assign rsp_last       = out_ff.last;

   fla_engine #(
      .MAX_FACILITIES(MAX_FACILITIES),
      .MAX_CLIENTS(MAX_CLIENTS)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .load(load),
      .start(start),
      .mode(req_mode),
      .row(req_row),
      .col(req_col),
      .value(req_value),
      .nf(nf),
      .nc(nc),
      .out_free(out_free),
      .busy(busy),
      .emit(emit)
   );

endmodule
